// ===== rtl/bounded_deque_with_search_assert.svh =====
// Assertion macros shared by the deque checker
`ifndef BOUNDED_DEQUE_WITH_SEARCH_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_ASSERT_SVH

// same-cycle implication, disabled while rstn is low
`define BDQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bdq: implication check failed");

// next-cycle implication, disabled while rstn is low
`define BDQ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bdq: next-cycle check failed");

`endif

// ===== rtl/bdq_pkg.sv =====
// Package: sizes, command and status codes, control structs and ring helper for the deque
`default_nettype none
package bdq_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int PTR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int OCC_W    = $clog2(CAPACITY + 1);
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DROP_FRONT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DROP_BACK  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_COUNT      = 3'd5;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic op_en;        // execute a command that needs no scan and load the result
        logic scan_start;   // latch key, clear index and found flag
        logic scan_issue;   // read the entry at the scan index
        logic load_search;  // load the search result
    } bdq_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic is_search;
        logic last;         // scan index is at the back entry
        logic out_free;     // result register can take a new result
    } bdq_stat_t;

    function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] base,
                                                  input logic [PTR_W-1:0] off);
        logic [PTR_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (PTR_W+1)'(CAPACITY)) begin
            sum = sum - (PTR_W+1)'(CAPACITY);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/bdq_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== rtl/bdq_dp.sv =====
// Datapath: ring pointers, entry store, scan compare and result register
`default_nettype none
module bdq_dp import bdq_pkg::*; (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire bdq_cmd_t                   ctl,
    output bdq_stat_t                       st,
    input  wire logic [CMD_W-1:0]           s_cmd,
    input  wire logic signed [DATA_W-1:0]   s_value,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [STATUS_W-1:0]             m_status,
    output logic                            m_found,
    output logic [COUNT_W-1:0]              m_count
);

    logic [PTR_W-1:0]    front_reg, front_next;
    logic [OCC_W-1:0]    occ_reg, occ_next;
    logic [PTR_W-1:0]    idx_reg, idx_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic [DATA_W-1:0]   key_reg, key_next;
    logic                found_reg, found_next;
    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    logic                m_found_reg, m_found_next;
    logic [COUNT_W-1:0]  m_count_reg, m_count_next;

    logic [STATUS_W-1:0]     op_status;
    logic                    full, empty;
    logic [PTR_W-1:0]        front_dec, front_inc;
    logic                    we;
    logic [PTR_W-1:0]        waddr, raddr;
    logic [DATA_W-1:0]       rdata;
    logic [OCC_W+COUNT_W-1:0] cnt_ext;

    assign full      = (occ_reg == OCC_W'(CAPACITY));
    assign empty     = (occ_reg == '0);
    assign front_dec = (front_reg == '0) ? PTR_W'(CAPACITY - 1) : front_reg - 1'b1;
    assign front_inc = (front_reg == PTR_W'(CAPACITY - 1)) ? '0 : front_reg + 1'b1;
    assign raddr     = ring_add(front_reg, idx_reg);

    bdq_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (s_value),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb begin
        occ_next   = occ_reg;
        front_next = front_reg;
        we         = 1'b0;
        waddr      = ring_add(front_reg, occ_reg[PTR_W-1:0]);
        op_status  = ST_DONE;
        if (ctl.op_en) begin
            case (s_cmd)
                CMD_PUSH_BACK: begin
                    if (full) begin
                        op_status = ST_FULL;
                    end else begin
                        we       = 1'b1;
                        occ_next = occ_reg + 1'b1;
                    end
                end
                CMD_PUSH_FRONT: begin
                    if (full) begin
                        op_status = ST_FULL;
                    end else begin
                        we         = 1'b1;
                        waddr      = front_dec;
                        front_next = front_dec;
                        occ_next   = occ_reg + 1'b1;
                    end
                end
                CMD_DROP_FRONT: begin
                    if (empty) begin
                        op_status = ST_EMPTY;
                    end else begin
                        front_next = front_inc;
                        occ_next   = occ_reg - 1'b1;
                    end
                end
                CMD_DROP_BACK: begin
                    if (empty) begin
                        op_status = ST_EMPTY;
                    end else begin
                        occ_next = occ_reg - 1'b1;
                    end
                end
                CMD_SEARCH: begin
                    op_status = ST_EMPTY;   // only reaches here when empty
                end
                default: begin
                    op_status = ST_DONE;
                end
            endcase
        end
    end

    always_comb begin
        idx_next       = idx_reg;
        key_next       = key_reg;
        found_next     = found_reg;
        cmp_valid_next = ctl.scan_issue;
        if (ctl.scan_start) begin
            idx_next   = '0;
            key_next   = s_value;
            found_next = 1'b0;
        end else begin
            if (ctl.scan_issue) begin
                idx_next = idx_reg + 1'b1;
            end
            if (cmp_valid_reg && (rdata == key_reg)) begin
                found_next = 1'b1;
            end
        end
    end

    always_comb begin
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_found_next  = m_found_reg;
        cnt_ext       = {COUNT_W'(0), occ_next};
        m_count_next  = m_count_reg;
        if (ctl.op_en) begin
            m_valid_next  = 1'b1;
            m_status_next = op_status;
            m_found_next  = 1'b0;
            m_count_next  = cnt_ext[COUNT_W-1:0];
        end else if (ctl.load_search) begin
            m_valid_next  = 1'b1;
            m_status_next = ST_DONE;
            m_found_next  = found_reg;
            m_count_next  = cnt_ext[COUNT_W-1:0];
        end else if (m_ready) begin
            m_valid_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg     <= '0;
            occ_reg       <= '0;
            idx_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            front_reg     <= front_next;
            occ_reg       <= occ_next;
            idx_reg       <= idx_next;
            cmp_valid_reg <= cmp_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg      <= key_next;
        found_reg    <= found_next;
        m_status_reg <= m_status_next;
        m_found_reg  <= m_found_next;
        m_count_reg  <= m_count_next;
    end

    assign st.empty     = empty;
    assign st.is_search = (s_cmd == CMD_SEARCH);
    assign st.last      = (idx_reg == PTR_W'(occ_reg - 1'b1));
    assign st.out_free  = !m_valid_reg || m_ready;

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_found  = m_found_reg;
    assign m_count  = m_count_reg;

endmodule
`default_nettype wire

// ===== rtl/bdq_ctrl.sv =====
// Controller: accepts commands and sequences the search scan
`default_nettype none
module bdq_ctrl import bdq_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire bdq_stat_t st,
    output bdq_cmd_t       ctl
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_ready = (state_reg == S_IDLE) && st.out_free;
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next      = state_reg;
        ctl.op_en       = 1'b0;
        ctl.scan_start  = 1'b0;
        ctl.scan_issue  = 1'b0;
        ctl.load_search = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (st.is_search && !st.empty) begin
                        ctl.scan_start = 1'b1;
                        state_next     = S_SCAN;
                    end else begin
                        ctl.op_en = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                ctl.scan_issue = 1'b1;
                if (st.last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                state_next = S_FINISH;   // last compare lands here
            end
            S_FINISH: begin
                if (st.out_free) begin
                    ctl.load_search = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/bounded_deque_with_search.sv =====
// Top level: bounded deque of signed words with linear search
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_valid / s_ready  | s_cmd[2:0], s_value[31:0]
//  m_      | out | m_valid / m_ready  | m_status[1:0], m_found, m_count[4:0]
//
//  Push, drop, count and search-on-empty: result registered on acceptance.
//  Search: scans the store through the RAM read port one entry per cycle, then registers the result.
//  A new transfer is taken while the previous result is being taken by the sink.
//  Reset (aresetn low, synchronous) empties the store; no clearing pass.
//  m_ready low holds the result and stalls input once the result register is full.
`default_nettype none
module bounded_deque_with_search import bdq_pkg::*; (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [CMD_W-1:0]         s_cmd,
    input  wire logic signed [DATA_W-1:0] s_value,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [STATUS_W-1:0]           m_status,
    output logic                          m_found,
    output logic [COUNT_W-1:0]            m_count
);

    bdq_cmd_t  ctl;
    bdq_stat_t st;

    bdq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .ctl     (ctl)
    );

    bdq_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl),
        .st       (st),
        .s_cmd    (s_cmd),
        .s_value  (s_value),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_status (m_status),
        .m_found  (m_found),
        .m_count  (m_count)
    );

endmodule
`default_nettype wire

// ===== rtl/bdq_checker.sv =====
// Port-level checker for the deque, bound to the top level
`default_nettype none
`include "bounded_deque_with_search_assert.svh"
module bdq_checker import bdq_pkg::*; (
    input wire logic                     aclk,
    input wire logic                     aresetn,
    input wire logic                     m_valid,
    input wire logic                     m_ready,
    input wire logic [STATUS_W-1:0]      m_status,
    input wire logic                     m_found,
    input wire logic [COUNT_W-1:0]       m_count
);

    `BDQ_ASSERT_NXT(a_reset_clears, aclk, 1'b1, !aresetn, !m_valid)
    `BDQ_ASSERT_NXT(a_result_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_found) && $stable(m_count))
    `BDQ_ASSERT_IMP(a_full_count, aclk, aresetn, m_valid && (m_status == ST_FULL), m_count == COUNT_W'(CAPACITY))
    `BDQ_ASSERT_IMP(a_found_done, aclk, aresetn, m_valid && m_found, m_status == ST_DONE)
    `BDQ_ASSERT_IMP(a_empty_count, aclk, aresetn, m_valid && (m_status == ST_EMPTY), m_count == '0 && !m_found)

endmodule

bind bounded_deque_with_search bdq_checker u_bdq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_status (m_status),
    .m_found  (m_found),
    .m_count  (m_count)
);
`default_nettype wire

// ===== tb/bounded_deque_with_search_tb.sv =====
// Self-checking testbench for the bounded deque with search: directed table, then biased random traffic
`timescale 1ns / 1ps
module bounded_deque_with_search_tb;
    import bdq_pkg::*;

    localparam int          HALF_PERIOD   = 10;
    localparam int          RESET_CYCLES  = 11;
    localparam int unsigned RANDOM_ITEMS  = 750;
    localparam int          TAIL_CYCLES   = 40;
    localparam int          WATCHDOG_NS   = 4_000_000;

    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [COUNT_W-1:0]  count;
    } deque_result_t;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] value;
        bit                typed;
        deque_result_t     want;
    } stim_row_t;

    typedef enum {PH_FILL, PH_DRAIN, PH_MIX} traffic_mix_t;

    logic                     aclk     = 1'b0;
    logic                     aresetn  = 1'b0;
    logic                     s_valid  = 1'b0;
    logic                     s_ready;
    logic [CMD_W-1:0]         s_cmd    = CMD_COUNT;
    logic signed [DATA_W-1:0] s_value  = '0;
    logic                     m_valid;
    logic                     m_ready  = 1'b0;
    logic [STATUS_W-1:0]      m_status;
    logic                     m_found;
    logic [COUNT_W-1:0]       m_count;

    logic [DATA_W-1:0] shadow_words [CAPACITY];
    int unsigned       shadow_head = 0;
    int unsigned       shadow_held = 0;

    deque_result_t pending_results [$];
    stim_row_t     plan [$];

    int unsigned mismatches    = 0;
    int unsigned transfers_in  = 0;
    int unsigned results_seen  = 0;
    int unsigned search_hits   = 0;
    int unsigned refused_push  = 0;
    int unsigned empty_results = 0;
    int unsigned burst_left    = 0;

    int unsigned sink_cycle = 0;
    int unsigned sink_run   = 0;

    bounded_deque_with_search i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_cmd    (s_cmd),
        .s_value  (s_value),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_status (m_status),
        .m_found  (m_found),
        .m_count  (m_count)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic deque_step(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] value,
                              output deque_result_t res);
        int unsigned k;
        res.status = ST_DONE;
        res.found  = 1'b0;
        case (cmd)
            CMD_PUSH_BACK: begin
                if (shadow_held >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_words[(shadow_head + shadow_held) % CAPACITY] = value;
                    shadow_held++;
                end
            end
            CMD_PUSH_FRONT: begin
                if (shadow_held >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_head = (shadow_head + CAPACITY - 1) % CAPACITY;
                    shadow_words[shadow_head] = value;
                    shadow_held++;
                end
            end
            CMD_DROP_FRONT: begin
                if (shadow_held == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    shadow_head = (shadow_head + 1) % CAPACITY;
                    shadow_held--;
                end
            end
            CMD_DROP_BACK: begin
                if (shadow_held == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    shadow_held--;
                end
            end
            CMD_SEARCH: begin
                if (shadow_held == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    for (k = 0; k < shadow_held; k++) begin
                        if (shadow_words[(shadow_head + k) % CAPACITY] == value) begin
                            res.found = 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        res.count = COUNT_W'(shadow_held);
    endtask

    // drive one command, wait for its transfer, then book the expected result
    task automatic issue(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] value,
                         input bit typed, input deque_result_t typed_want);
        deque_result_t res;
        int unsigned   gap;
        s_valid <= 1'b1;
        s_cmd   <= cmd;
        s_value <= value;
        do @(posedge aclk); while (!s_ready);
        deque_step(cmd, value, res);
        pending_results.push_back(typed ? typed_want : res);
        transfers_in++;
        if (res.found) search_hits++;
        if (res.status == ST_FULL) refused_push++;
        if (res.status == ST_EMPTY) empty_results++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] value,
                           input bit typed, input logic [STATUS_W-1:0] st,
                           input logic fnd, input logic [COUNT_W-1:0] cnt);
        stim_row_t r;
        r.cmd         = cmd;
        r.value       = value;
        r.typed       = typed;
        r.want.status = st;
        r.want.found  = fnd;
        r.want.count  = cnt;
        plan.push_back(r);
    endtask

    function automatic logic [CMD_W-1:0] pick_cmd(input traffic_mix_t mix);
        int unsigned      r;
        int unsigned      acc;
        int unsigned      i;
        int unsigned      w [6];
        logic [CMD_W-1:0] order [6];
        order = '{CMD_PUSH_BACK, CMD_PUSH_FRONT, CMD_DROP_FRONT, CMD_DROP_BACK,
                  CMD_SEARCH, CMD_COUNT};
        case (mix)
            PH_FILL:  w = '{35, 30, 8, 7, 15, 3};
            PH_DRAIN: w = '{10, 10, 25, 25, 22, 6};
            default:  w = '{20, 20, 15, 15, 22, 6};
        endcase
        r   = $urandom_range(0, 99);
        acc = 0;
        for (i = 0; i < 6; i++) begin
            acc += w[i];
            if (r < acc) return order[i];
        end
        return $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;
    endfunction

    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            4:       return DATA_W'($urandom_range(0, 15));
            default: return $urandom;
        endcase
    endfunction

    // mostly keys that are held, so that hits are common
    function automatic logic [DATA_W-1:0] pick_key();
        if (shadow_held != 0 && $urandom_range(0, 99) < 60) begin
            return shadow_words[(shadow_head + $urandom_range(0, shadow_held - 1)) % CAPACITY];
        end
        return pick_word();
    endfunction

    always @(posedge aclk) begin
        sink_cycle <= sink_cycle + 1;
        if (sink_cycle[9:8] == 2'd0) begin
            m_ready <= 1'b1;
        end else if (sink_run != 0) begin
            sink_run <= sink_run - 1;
        end else begin
            m_ready  <= !m_ready;
            sink_run <= m_ready ? $urandom_range(0, 10) : $urandom_range(0, 25);
        end
    end

    always @(posedge aclk) begin
        deque_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                flag_mismatch("result with nothing outstanding", 32'(m_count), 32'd0);
            end else begin
                want = pending_results.pop_front();
                if (m_status !== want.status)
                    flag_mismatch("status", 32'(m_status), 32'(want.status));
                if (m_found !== want.found)
                    flag_mismatch("found", 32'(m_found), 32'(want.found));
                if (m_count !== want.count)
                    flag_mismatch("count", 32'(m_count), 32'(want.count));
            end
        end
    end

    initial begin
        #(WATCHDOG_NS);
        $display("timed out with %0d results outstanding", pending_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        traffic_mix_t  mix;
        int unsigned   mix_left;
        int unsigned   real_items;
        int unsigned   i;
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] value;

        add_row(CMD_COUNT,      32'h0,         1'b1, ST_DONE,  1'b0, 5'd0);
        add_row(CMD_DROP_FRONT, 32'h0,         1'b1, ST_EMPTY, 1'b0, 5'd0);
        add_row(CMD_DROP_BACK,  32'h0,         1'b1, ST_EMPTY, 1'b0, 5'd0);
        add_row(CMD_SEARCH,     32'h0,         1'b1, ST_EMPTY, 1'b0, 5'd0);
        add_row(CMD_SPARE_6,    32'hFFFF_FFFF, 1'b1, ST_DONE,  1'b0, 5'd0);
        add_row(CMD_SPARE_7,    32'h5555_AAAA, 1'b1, ST_DONE,  1'b0, 5'd0);
        add_row(CMD_PUSH_BACK,  32'h7FFF_FFFF, 1'b1, ST_DONE,  1'b0, 5'd1);
        add_row(CMD_PUSH_FRONT, 32'h8000_0000, 1'b1, ST_DONE,  1'b0, 5'd2);
        add_row(CMD_SEARCH,     32'h8000_0000, 1'b1, ST_DONE,  1'b1, 5'd2);
        for (i = 0; i < CAPACITY - 2; i++) begin
            add_row(i[0] ? CMD_PUSH_FRONT : CMD_PUSH_BACK, $urandom, 1'b0, ST_DONE, 1'b0, '0);
        end
        add_row(CMD_PUSH_BACK,  32'h1234_5678, 1'b1, ST_FULL,  1'b0, 5'd16);
        add_row(CMD_PUSH_FRONT, 32'h8765_4321, 1'b1, ST_FULL,  1'b0, 5'd16);
        add_row(CMD_SEARCH,     32'h7FFF_FFFF, 1'b1, ST_DONE,  1'b1, 5'd16);
        add_row(CMD_DROP_FRONT, 32'h0,         1'b0, ST_DONE,  1'b0, '0);
        add_row(CMD_DROP_BACK,  32'h0,         1'b0, ST_DONE,  1'b0, '0);

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[n]) begin
            issue(plan[n].cmd, plan[n].value, plan[n].typed, plan[n].want);
        end
        drain_results();

        mix        = PH_FILL;
        mix_left   = 40;
        real_items = 0;
        while (real_items < RANDOM_ITEMS) begin
            if (mix_left == 0) begin
                mix      = traffic_mix_t'($urandom_range(0, 2));
                mix_left = $urandom_range(20, 60);
            end
            mix_left--;
            cmd   = pick_cmd(mix);
            value = (cmd == CMD_SEARCH) ? pick_key() : pick_word();
            issue(cmd, value, 1'b0, '0);
            if (cmd <= CMD_COUNT) begin
                real_items++;
                if (real_items == RANDOM_ITEMS / 2) drain_results();
            end
        end
        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("%0d transfers in, %0d results checked", transfers_in, results_seen);
        $display("%0d search hits, %0d pushes refused on a full store, %0d empty-store results",
                 search_hits, refused_push, empty_results);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
